FILE: sv/preemptive_priority_core_scheduler_defines.svh
// Assertion macros shared by the scheduler RTL.
// Include by bare file name; the macros expect i_clk and i_rst_n in scope.
`ifndef PREEMPTIVE_PRIORITY_CORE_SCHEDULER_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_CORE_SCHEDULER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPCS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ppcs_pkg.sv
// Shared types and constants for the preemptive priority core scheduler.
// No dependencies; used by ppcs_cmp and the top level.
package ppcs_pkg;

    // Table sizes.
    localparam int MAX_PROCS = 64;
    localparam int MAX_CORES = 8;
    localparam int PROC_W    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CORE_W    = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int NP_W      = $clog2(MAX_PROCS + 1);
    localparam int NC_W      = $clog2(MAX_CORES + 1);
    localparam int TAG_W     = CORE_W + PROC_W;

    // Field widths.
    localparam int ACT_W      = 2;
    localparam int ID_W       = 6;
    localparam int PRIO_W     = 8;
    localparam int OUT_CORE_W = 3;
    localparam int CTX_W      = 32;
    localparam int FIN_W      = 7;

    // Configuration port.
    localparam int CFG_CORE_W = 4;
    localparam int CFG_PROC_W = 7;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_CORE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PROC_COUNT = 1'b1;
    localparam logic [CFG_CORE_W-1:0] CORE_COUNT_RST = 4'd8;
    localparam logic [CFG_PROC_W-1:0] PROC_COUNT_RST = 7'd64;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_ARRIVE   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_COMPLETE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SCHED    = 2'd2;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_PSCAN,
        S_PLAST,
        S_CSTART,
        S_CSCAN,
        S_CLAST,
        S_DECIDE,
        S_OUT
    } t_state;

    // Control into the shared compare unit.
    typedef struct packed {
        logic             clr;
        logic             vld;
        logic             want_max;
        logic [TAG_W-1:0] tag;
    } t_cmp_ctl;

    // Running best held by the compare unit.
    typedef struct packed {
        logic                     have;
        logic signed [PRIO_W-1:0] val;
        logic [TAG_W-1:0]         tag;
    } t_cmp_res;

endpackage

FILE: sv/ppcs_cmp.sv
// Shared priority compare unit: keeps the running maximum or minimum of a scan.
// Depends on ppcs_pkg for the control and result structs.
module ppcs_cmp
    import ppcs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmp_ctl                 i_ctl,
    input  logic signed [PRIO_W-1:0] i_val,
    output t_cmp_res                 o_res
);

    logic                     r_have;
    logic signed [PRIO_W-1:0] r_val;
    logic [TAG_W-1:0]         r_tag;
    logic                     better;

    // Strict compare keeps the first entry among equals.
    always_comb begin
        if (i_ctl.want_max) begin
            better = (i_val > r_val);
        end else begin
            better = (i_val < r_val);
        end
    end

    // Running best; a clear starts a new scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_ctl.clr) begin
            r_have <= 1'b0;
        end else if (i_ctl.vld && (!r_have || better)) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_ctl.clr && i_ctl.vld && (!r_have || better)) begin
            r_val <= i_val;
            r_tag <= i_ctl.tag;
        end
    end

    assign o_res = '{have: r_have, val: r_val, tag: r_tag};

endmodule

FILE: sv/preemptive_priority_core_scheduler.sv
// Top level of the preemptive priority core scheduler: sequencer, process table
// and core state. Depends on ppcs_pkg, ppcs_cmp and the assertion macro header.
//
// Channel   Dir  Handshake             Beat
// input     in   i_valid / o_stall     action, proc_id, proc_priority
// result    out  o_valid / i_stall     one result beat per input beat
// config    in   i_cfg_we              i_cfg_idx, i_cfg_data
//
// Arrival, completion and unused actions pass through S_EXEC and S_OUT from accept to result.
// A schedule step scans the process table, then the cores (np, nc: effective process and core
// counts): one priority memory read per process slot, then one per core.
// o_stall is high from accept until the result is loaded into the output register.
// A held output register delays only the final load; reset is synchronous, active low.
`include "preemptive_priority_core_scheduler_defines.svh"

module preemptive_priority_core_scheduler
    import ppcs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [ACT_W-1:0]         i_action,
    input  logic [ID_W-1:0]          i_proc_id,
    input  logic signed [PRIO_W-1:0] i_proc_priority,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_assigned,
    output logic [ID_W-1:0]          o_assigned_proc,
    output logic [OUT_CORE_W-1:0]    o_assigned_core,
    output logic                     o_preempted,
    output logic [ID_W-1:0]          o_preempted_proc,
    output logic [CTX_W-1:0]         o_context_change_count,
    output logic [FIN_W-1:0]         o_finished_count,
    output logic                     o_all_finished
);

    // Sequencer and configuration.
    t_state                  r_state, n_state;
    logic [CFG_CORE_W-1:0]   r_core_count;
    logic [CFG_PROC_W-1:0]   r_proc_count;
    logic [NC_W-1:0]         nc;
    logic [NP_W-1:0]         np;

    // Latched input beat.
    logic [ACT_W-1:0]         r_action;
    logic [PROC_W-1:0]        r_id;
    logic signed [PRIO_W-1:0] r_prio;

    // Process and core state.
    logic signed [PRIO_W-1:0] prio_mem [MAX_PROCS];
    logic [MAX_PROCS-1:0]     r_arrived, r_running, r_done;
    logic [MAX_CORES-1:0]     r_busy;
    logic [PROC_W-1:0]        r_owner [MAX_CORES];
    logic [CTX_W-1:0]         r_ctx;
    logic [FIN_W-1:0]         r_done_total;

    // Scan counters and read pipeline.
    logic [PROC_W-1:0]        r_idx;
    logic [CORE_W-1:0]        r_cidx;
    logic                     p_last, c_last;
    logic [PROC_W-1:0]        rd_addr;
    logic signed [PRIO_W-1:0] r_rd_data;
    logic                     r_pipe_vld;
    logic                     r_pipe_max;
    logic [TAG_W-1:0]         r_pipe_tag;
    logic                     mem_we;
    t_cmp_ctl                 cmp_ctl;
    t_cmp_res                 cmp_res;

    // Candidate kept across the core scan.
    logic                     r_have_cand;
    logic [PROC_W-1:0]        r_cand;
    logic signed [PRIO_W-1:0] r_cand_prio;

    // Decision terms.
    logic                     any_free;
    logic [CORE_W-1:0]        first_free;
    logic                     d_asg, d_pre;
    logic [CORE_W-1:0]        d_core;
    logic [PROC_W-1:0]        d_victim;

    // Staged result and output register.
    logic                     r_res_asg, r_res_pre;
    logic [PROC_W-1:0]        r_res_proc, r_res_victim;
    logic [CORE_W-1:0]        r_res_core;
    logic                     r_out_vld;
    logic                     out_free;
    logic                     in_acc;

    // Effective counts clamped to the table sizes.
    always_comb begin
        if (r_core_count == '0) begin
            nc = NC_W'(1);
        end else if (32'(r_core_count) > 32'(MAX_CORES)) begin
            nc = NC_W'(MAX_CORES);
        end else begin
            nc = NC_W'(r_core_count);
        end
        if (r_proc_count == '0) begin
            np = NP_W'(1);
        end else if (32'(r_proc_count) > 32'(MAX_PROCS)) begin
            np = NP_W'(MAX_PROCS);
        end else begin
            np = NP_W'(r_proc_count);
        end
    end

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_vld || !i_stall;
    assign p_last   = (32'(r_idx) == 32'(np) - 32'd1);
    assign c_last   = (32'(r_cidx) == 32'(nc) - 32'd1);

    // First free core below the effective core count.
    always_comb begin
        any_free   = 1'b0;
        first_free = '0;
        for (int i = MAX_CORES - 1; i >= 0; i--) begin
            if ((32'(i) < 32'(nc)) && !r_busy[i]) begin
                any_free   = 1'b1;
                first_free = CORE_W'(i);
            end
        end
    end

    // Placement decision once both scans are done.
    always_comb begin
        d_asg    = 1'b0;
        d_pre    = 1'b0;
        d_core   = first_free;
        d_victim = cmp_res.tag[PROC_W-1:0];
        if (r_have_cand) begin
            if (any_free) begin
                d_asg = 1'b1;
            end else if (r_cand_prio > cmp_res.val) begin
                d_asg  = 1'b1;
                d_pre  = 1'b1;
                d_core = cmp_res.tag[TAG_W-1:PROC_W];
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = (r_action == ACT_SCHED) ? S_PSCAN : S_OUT;
            end
            S_PSCAN: begin
                if (p_last) begin
                    n_state = S_PLAST;
                end
            end
            S_PLAST:  n_state = S_CSTART;
            S_CSTART: n_state = S_CSCAN;
            S_CSCAN: begin
                if (c_last) begin
                    n_state = S_CLAST;
                end
            end
            S_CLAST:  n_state = S_DECIDE;
            S_DECIDE: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: stall, memory port and compare unit control.
    always_comb begin
        o_stall     = (r_state != S_IDLE);
        mem_we      = 1'b0;
        rd_addr     = r_idx;
        cmp_ctl.clr = 1'b0;
        cmp_ctl.vld = r_pipe_vld;
        cmp_ctl.want_max = r_pipe_max;
        cmp_ctl.tag = r_pipe_tag;
        case (r_state)
            S_EXEC: begin
                mem_we      = (r_action == ACT_ARRIVE) && !r_arrived[r_id] && !r_done[r_id]
                              && (32'(r_id) < 32'(MAX_PROCS));
                cmp_ctl.clr = 1'b1;
            end
            S_CSTART: begin
                cmp_ctl.clr = 1'b1;
            end
            S_CSCAN: begin
                rd_addr = r_owner[r_cidx];
            end
            default: begin
                rd_addr = r_idx;
            end
        endcase
    end

    // Priority memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            prio_mem[r_id] <= r_prio;
        end
        r_rd_data <= prio_mem[rd_addr];
    end

    // Read pipeline tags that travel with each memory read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe_vld <= 1'b0;
        end else if (r_state == S_PSCAN) begin
            r_pipe_vld <= r_arrived[r_idx] && !r_running[r_idx] && !r_done[r_idx];
        end else begin
            r_pipe_vld <= (r_state == S_CSCAN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pipe_max <= (r_state == S_PSCAN);
        if (r_state == S_CSCAN) begin
            r_pipe_tag <= {r_cidx, r_owner[r_cidx]};
        end else begin
            r_pipe_tag <= TAG_W'(r_idx);
        end
    end

    ppcs_cmp u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cmp_ctl),
        .i_val   (r_rd_data),
        .o_res   (cmp_res)
    );

    // Control state, configuration and the process and core tables.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_core_count <= CORE_COUNT_RST;
            r_proc_count <= PROC_COUNT_RST;
            r_arrived    <= '0;
            r_running    <= '0;
            r_done       <= '0;
            r_busy       <= '0;
            r_ctx        <= '0;
            r_done_total <= '0;
            r_have_cand  <= 1'b0;
            r_res_asg    <= 1'b0;
            r_res_pre    <= 1'b0;
            r_out_vld    <= 1'b0;
            for (int i = 0; i < MAX_CORES; i++) begin
                r_owner[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CORE_COUNT: r_core_count <= i_cfg_data[CFG_CORE_W-1:0];
                    REG_PROC_COUNT: r_proc_count <= i_cfg_data[CFG_PROC_W-1:0];
                    default: begin
                        r_core_count <= r_core_count;
                    end
                endcase
            end

            // Output register loads at the end of an item and drains on a taken beat.
            if ((r_state == S_OUT) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_stall) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_res_asg <= 1'b0;
                        r_res_pre <= 1'b0;
                    end
                end
                S_EXEC: begin
                    if (mem_we) begin
                        r_arrived[r_id] <= 1'b1;
                    end
                    if ((r_action == ACT_COMPLETE) && (32'(r_id) < 32'(MAX_PROCS))
                        && !r_done[r_id]) begin
                        r_done[r_id]    <= 1'b1;
                        r_running[r_id] <= 1'b0;
                        if (r_done_total != '1) begin
                            r_done_total <= r_done_total + FIN_W'(1);
                        end
                        for (int i = 0; i < MAX_CORES; i++) begin
                            if (r_busy[i] && (r_owner[i] == r_id)) begin
                                r_busy[i] <= 1'b0;
                            end
                        end
                    end
                end
                S_CSTART: begin
                    r_have_cand <= cmp_res.have;
                end
                S_DECIDE: begin
                    if (d_pre) begin
                        r_running[d_victim] <= 1'b0;
                        if (r_ctx != '1) begin
                            r_ctx <= r_ctx + CTX_W'(1);
                        end
                    end
                    if (d_asg) begin
                        r_busy[d_core]    <= 1'b1;
                        r_owner[d_core]   <= r_cand;
                        r_running[r_cand] <= 1'b1;
                    end
                    r_res_asg <= d_asg;
                    r_res_pre <= d_pre;
                end
                default: begin
                    r_res_asg <= r_res_asg;
                end
            endcase
        end
    end

    // Payload registers: latched beat, scan counters, candidate and result.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action <= i_action;
            r_id     <= PROC_W'(i_proc_id);
            r_prio   <= i_proc_priority;
        end
        if (r_state == S_EXEC) begin
            r_idx <= '0;
        end else if (r_state == S_PSCAN && !p_last) begin
            r_idx <= r_idx + PROC_W'(1);
        end
        if (r_state == S_CSTART) begin
            r_cidx <= '0;
        end else if (r_state == S_CSCAN && !c_last) begin
            r_cidx <= r_cidx + CORE_W'(1);
        end
        if (r_state == S_CSTART) begin
            r_cand      <= cmp_res.tag[PROC_W-1:0];
            r_cand_prio <= cmp_res.val;
        end
        if (r_state == S_DECIDE) begin
            r_res_proc   <= r_cand;
            r_res_core   <= d_core;
            r_res_victim <= d_victim;
        end
        if (r_state == S_OUT && out_free) begin
            o_assigned             <= r_res_asg;
            o_assigned_proc        <= r_res_asg ? ID_W'(r_res_proc) : '0;
            o_assigned_core        <= r_res_asg ? OUT_CORE_W'(r_res_core) : '0;
            o_preempted            <= r_res_pre;
            o_preempted_proc       <= r_res_pre ? ID_W'(r_res_victim) : '0;
            o_context_change_count <= r_ctx;
            o_finished_count       <= r_done_total;
            o_all_finished         <= (32'(r_done_total) == 32'(np));
        end
    end

    assign o_valid = r_out_vld;

    // A preemption always frees a core for the candidate.
    `PPCS_ASSERT_SAME(a_pre_asg, o_valid && o_preempted, o_assigned, "preempt, no placement")
    // The preemption counter moves by at most one per decision.
    `PPCS_ASSERT_NEXT(a_ctx_step, r_state == S_DECIDE, (r_ctx - $past(r_ctx)) <= CTX_W'(1), "ctx jump")
    // A placed process is marked running afterwards.
    `PPCS_ASSERT_NEXT(a_asg_run, (r_state == S_DECIDE) && d_asg, r_running[$past(r_cand)], "not running")
    // The core that received it is marked busy afterwards.
    `PPCS_ASSERT_NEXT(a_asg_busy, (r_state == S_DECIDE) && d_asg, r_busy[$past(d_core)], "core free")

endmodule
